>>> design/breathing_led_triangle_pwm_assert.svh
// ---------------------------------------------------------------------------
// Breathing LED PWM assertion macros
// Shared property forms for the port checker. Clock clk, reset rst.
// ---------------------------------------------------------------------------
`ifndef BREATHING_LED_TRIANGLE_PWM_ASSERT_SVH
`define BREATHING_LED_TRIANGLE_PWM_ASSERT_SVH

// Same-cycle implication.
`define BLT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("breathing pwm check failed");

// Next-cycle implication.
`define BLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("breathing pwm check failed");

`endif

>>> design/blt_pkg.sv
// ---------------------------------------------------------------------------
// Breathing LED PWM package
// Widths, register indexes and handshake structs shared by the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package blt_pkg;

  localparam int LEVEL_W  = 16;
  localparam int PERIOD_W = 17;
  localparam int PROD_W   = 32;
  localparam int DUTY_W   = 10;
  localparam int CNT_W    = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [PERIOD_W-1:0] MIN_PERIOD = 17'd4;
  localparam logic [LEVEL_W-1:0]  RAMP_STEP  = 16'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b1;

  typedef struct packed {
    logic               start;
    logic [PROD_W-1:0]  dividend;
    logic [LEVEL_W-1:0] divisor;
  } div_ctl_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_sts_t;

endpackage

>>> design/blt_div.sv
// ---------------------------------------------------------------------------
// Breathing LED PWM divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module blt_div
  import blt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_ctl_t ctl,
  output div_sts_t sts
);

  logic [LEVEL_W-1:0] rem;
  logic [PROD_W-1:0]  quo;
  logic [LEVEL_W-1:0] dvs;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;

  logic [LEVEL_W:0]   shifted;
  logic               ge;

  always_comb begin
    shifted = {rem, quo[PROD_W-1]};
    ge      = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      quo <= ctl.dividend;
      dvs <= ctl.divisor;
    end else if (busy) begin
      // trial subtract; keep the shifted remainder when it falls short
      rem <= ge ? LEVEL_W'(shifted - {1'b0, dvs}) : shifted[LEVEL_W-1:0];
      quo <= {quo[PROD_W-2:0], ge};
    end
  end

  assign sts.done     = done;
  assign sts.quotient = quo;

endmodule

>>> design/breathing_led_triangle_pwm.sv
// ---------------------------------------------------------------------------
// Breathing LED triangle-wave PWM duty
// Ramp a level up and down by 2 per breathing tick, emit level*scale/half (0 when off or period < 4).
// ---------------------------------------------------------------------------
// Each tick is one transfer on the input channel. A tick not from the
// breathing timer is taken while the block stays idle and gives no result.
// A breathing tick gives one duty transfer. With the ramp off or the period
// below 4 the duty is 0 and goes straight to the output load. Otherwise the
// duty passes a multiply by the full scale, the start of the serial divider,
// the divider steps, the capture of the quotient and the load of the output
// register. The load waits while a previous duty still sits in the output
// register, and the input is not ready until the duty has been placed in the
// output register. The output register holds a finished duty until it is
// taken, and the input is ready again meanwhile.
`timescale 1ns / 1ps

module breathing_led_triangle_pwm
  import blt_pkg::*;
#(
  parameter int unsigned DUTY_FULL_SCALE = 999
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 from_breathing_timer,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DUTY_W-1:0]    duty_compare
);

  localparam logic [LEVEL_W-1:0] SCALE = LEVEL_W'(DUTY_FULL_SCALE);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_GO   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state;
  logic                breathing_enable;
  logic [PERIOD_W-1:0] breath_period_ticks;
  logic [LEVEL_W-1:0]  ramp_level;
  logic                ramp_rising;
  logic [LEVEL_W-1:0]  half;
  logic [PROD_W-1:0]   product;
  logic [DUTY_W-1:0]   result;

  logic [LEVEL_W-1:0]  ramp_level_next;
  logic                ramp_rising_next;
  logic [LEVEL_W-1:0]  level_clamped;
  logic [LEVEL_W-1:0]  half_now;
  logic                run;
  logic                in_xfer;

  div_ctl_t div_ctl;
  div_sts_t div_sts;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign run       = breathing_enable && (breath_period_ticks >= MIN_PERIOD);
  assign half_now  = breath_period_ticks[PERIOD_W-1:1];

  always_comb begin
    level_clamped    = (ramp_level > half_now) ? half_now : ramp_level;
    ramp_level_next  = level_clamped;
    ramp_rising_next = ramp_rising;
    if (ramp_rising) begin
      if (({1'b0, level_clamped} + {1'b0, RAMP_STEP}) >= {1'b0, half_now}) begin
        ramp_level_next  = half_now;
        ramp_rising_next = 1'b0;
      end else begin
        ramp_level_next = level_clamped + RAMP_STEP;
      end
    end else begin
      if (level_clamped <= RAMP_STEP) begin
        ramp_level_next  = '0;
        ramp_rising_next = 1'b1;
      end else begin
        ramp_level_next = level_clamped - RAMP_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      breathing_enable    <= 1'b0;
      breath_period_ticks <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE: breathing_enable    <= cfg_data[0];
        REG_PERIOD: breath_period_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ramp_level  <= '0;
      ramp_rising <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      // S_DONE owns out_valid itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer && from_breathing_timer) begin
            if (run) begin
              ramp_level  <= ramp_level_next;
              ramp_rising <= ramp_rising_next;
              state       <= S_MUL;
            end else begin
              ramp_level  <= '0;
              ramp_rising <= 1'b1;
              state       <= S_DONE;
            end
          end
        end
        S_MUL:  state <= S_GO;
        S_GO:   state <= S_DIV;
        S_DIV: begin
          if (div_sts.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // load the output register once the previous duty has left
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_xfer && from_breathing_timer) begin
      half   <= half_now;
      result <= '0;
    end
    if (state == S_MUL) begin
      product <= {16'b0, ramp_level} * {16'b0, SCALE};
    end
    if (state == S_DIV && div_sts.done) begin
      result <= div_sts.quotient[DUTY_W-1:0];
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      duty_compare <= result;
    end
  end

  assign div_ctl.start    = (state == S_GO);
  assign div_ctl.dividend = product;
  assign div_ctl.divisor  = half;

  blt_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_ctl),
    .sts (div_sts)
  );

endmodule

>>> design/blt_chk.sv
// ---------------------------------------------------------------------------
// Breathing LED PWM port checker
// Watches the top-level ports for sequencing slips; bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "breathing_led_triangle_pwm_assert.svh"

module blt_chk
  import blt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              from_breathing_timer,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DUTY_W-1:0] duty_compare
);

  // a breathing tick occupies the block
  `BLT_ASSERT_NEXT(a_busy_after_tick, in_valid && in_ready && from_breathing_timer, !in_ready)

  // a foreign tick is dropped at once
  `BLT_ASSERT_NEXT(a_foreign_free, in_valid && in_ready && !from_breathing_timer, in_ready)

  // a new duty only appears from the busy sequence
  `BLT_ASSERT_SAME(a_rise_from_busy, $rose(out_valid), $past(!in_ready))

  // a stalled duty holds
  `BLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(duty_compare))

endmodule

bind breathing_led_triangle_pwm blt_chk u_chk (.*);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Breathing LED triangle PWM testbench
// Drives timer ticks and register writes through the valid/ready channels,
// predicts each duty transfer from a local copy of the ramp, and compares
// every duty the block emits against the oldest prediction.
// ---------------------------------------------------------------------------

module testbench;
  import blt_pkg::*;

  localparam int unsigned DUTY_SCALE    = 999;
  localparam int          TICK_TARGET   = 1650;
  localparam int          SETTLE_CYCLES = 48;
  localparam int          LONG_HOLD     = 300;
  localparam longint      CYCLE_LIMIT   = 1500000;

  class duty_scoreboard;
    bit                  enable;
    logic [PERIOD_W-1:0] period;
    logic [LEVEL_W-1:0]  level;
    bit                  rising;
    logic [DUTY_W-1:0]   pending_duty[$];
    int                  mismatches;

    function new();
      enable     = 1'b0;
      period     = '0;
      level      = '0;
      rising     = 1'b1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] data);
      case (idx)
        REG_ENABLE: enable = data[0];
        REG_PERIOD: period = data;
        default: ;
      endcase
    endfunction

    // Step the ramp for one accepted tick and queue the duty it yields.
    function void note_tick(bit from_bt);
      logic [LEVEL_W-1:0] half;
      logic [63:0]        ratio;
      if (!from_bt) return;
      if (!enable || period < MIN_PERIOD) begin
        level  = '0;
        rising = 1'b1;
        pending_duty.push_back('0);
        return;
      end
      half = period[PERIOD_W-1:1];
      if (level > half) level = half;
      if (rising) begin
        if ({1'b0, level} + {1'b0, RAMP_STEP} >= {1'b0, half}) begin
          level  = half;
          rising = 1'b0;
        end else begin
          level = level + RAMP_STEP;
        end
      end else begin
        if (level <= RAMP_STEP) begin
          level  = '0;
          rising = 1'b1;
        end else begin
          level = level - RAMP_STEP;
        end
      end
      ratio = (64'(level) * 64'(DUTY_SCALE)) / 64'(half);
      pending_duty.push_back(ratio[DUTY_W-1:0]);
    endfunction

    function void check_duty(logic [DUTY_W-1:0] got);
      logic [DUTY_W-1:0] want;
      if (pending_duty.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected duty transfer: got %0d", got);
        return;
      end
      want = pending_duty.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("duty_compare mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PERIOD_W-1:0]  cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 from_breathing_timer;
  logic                 out_valid;
  logic                 out_ready;
  logic [DUTY_W-1:0]    duty_compare;

  duty_scoreboard sb;
  bit             steady        = 1'b0;
  bit             long_hold_req = 1'b0;
  int             ticks_sent    = 0;
  longint         cycle_count   = 0;

  breathing_led_triangle_pwm #(
    .DUTY_FULL_SCALE(DUTY_SCALE)
  ) dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .from_breathing_timer(from_breathing_timer),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .duty_compare        (duty_compare)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("breathing_led_triangle_pwm test failed");
      $finish;
    end
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(3, 1);
    if (pick < 98) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  // Duty receiver: check each transfer, then pick ready for the next cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_duty(duty_compare);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && !steady) begin
        hold_left = gap_len();
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input bit from_bt);
    int pause;
    in_valid <= 1'b1;
    from_breathing_timer <= from_bt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(from_bt);
    ticks_sent++;
    pause = steady ? 0 : gap_len();
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  // Hold the input until every predicted duty has been taken, then let a
  // possible divide in flight finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_duty.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [PERIOD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_regs(input bit wr_en, input logic [PERIOD_W-1:0] en_data,
                          input bit wr_per, input logic [PERIOD_W-1:0] per_data);
    drain();
    if (wr_en) cfg_write(REG_ENABLE, en_data);
    if (wr_per) cfg_write(REG_PERIOD, per_data);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                  phase;
    int                  n;
    int                  pick;
    logic [PERIOD_W-1:0] per;
    logic [PERIOD_W-1:0] en_data;
    sb = new();
    rst                  = 1'b1;
    cfg_valid            = 1'b0;
    cfg_index            = REG_ENABLE;
    cfg_data             = '0;
    in_valid             = 1'b0;
    from_breathing_timer = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Ramp off after reset, foreign tick ignored.
    send_tick(1'b1);
    send_tick(1'b0);
    set_regs(1'b1, 17'd1, 1'b1, 17'd3);
    send_tick(1'b1);
    set_regs(1'b0, '0, 1'b1, 17'd0);
    send_tick(1'b1);
    // Smallest working period: bounce between 0 and the top.
    set_regs(1'b0, '0, 1'b1, 17'd4);
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    set_regs(1'b0, '0, 1'b1, 17'h1FFFF);
    repeat (3) send_tick(1'b1);
    set_regs(1'b0, '0, 1'b1, 17'd40);
    repeat (12) send_tick(1'b1);
    // Shrink the period under the current level so it gets clamped.
    set_regs(1'b0, '0, 1'b1, 17'd8);
    repeat (2) send_tick(1'b1);
    // Enable write with bit 0 clear and the upper bits set.
    set_regs(1'b1, 17'h1FFFE, 1'b0, '0);
    send_tick(1'b1);

    phase = 0;
    while (ticks_sent < TICK_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        per = PERIOD_W'($urandom_range(3));
      end else if (pick < 60) begin
        per = PERIOD_W'($urandom_range(80, 4));
      end else if (pick < 75) begin
        per = PERIOD_W'($urandom_range(2000, 81));
      end else if (pick < 88) begin
        per = PERIOD_W'($urandom_range(131071));
      end else begin
        case ($urandom_range(3))
          0: per = 17'd4;
          1: per = 17'd5;
          2: per = 17'd131070;
          default: per = 17'h1FFFF;
        endcase
      end
      en_data = PERIOD_W'($urandom());
      en_data[0] = ($urandom_range(99) < 85);
      set_regs($urandom_range(3) != 0, en_data, $urandom_range(4) != 0, per);
      steady = ($urandom_range(4) == 0);
      // Stall the duty side long enough for the block to back up its input.
      if (phase == 2) long_hold_req = 1'b1;
      n = $urandom_range(60, 10);
      for (int k = 0; k < n; k++) begin
        if (phase == 4 && k == n / 2) drain();
        send_tick($urandom_range(99) < 85);
      end
      phase++;
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("breathing_led_triangle_pwm test passed");
    end else begin
      $display("breathing_led_triangle_pwm test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/blt_pkg.sv
design/blt_div.sv
design/breathing_led_triangle_pwm.sv
design/blt_chk.sv
verif/testbench.sv
